>>> src/slsss_pkg.sv
// package for the sprite line scan, select and sort block
// holds command codes, store lane codes, sprite entry and result types
// and the controller state type; no dependencies

package slsss_pkg;

	// command codes of an input transaction
	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_READ   = 2'd1,
		CMD_SCAN   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	// byte lanes of one sprite in the store
	localparam logic [1:0] LANE_Y    = 2'd0;
	localparam logic [1:0] LANE_X    = 2'd1;
	localparam logic [1:0] LANE_TILE = 2'd2;
	localparam logic [1:0] LANE_ATTR = 2'd3;

	// configuration register indexes
	localparam logic CFG_COLOR_MODE   = 1'b0;
	localparam logic CFG_TALL_SPRITES = 1'b1;

	// fixed geometry and masks
	localparam int          SPRITE_IDX_W   = 6;
	localparam logic [9:0]  Y_OFFSET       = 10'd16;
	localparam logic [8:0]  HEIGHT_SHORT   = 9'd8;
	localparam logic [8:0]  HEIGHT_TALL    = 9'd16;
	localparam logic [7:0]  ATTR_MASK_MONO = 8'hF0;

	// four bytes of one sprite as read from the store
	typedef struct packed {
		logic [7:0] y;
		logic [7:0] x;
		logic [7:0] tile;
		logic [7:0] attr;
	} sprite_bytes_t;

	// one picked sprite held in a cell of the sort chain
	typedef struct packed {
		logic [SPRITE_IDX_W-1:0] idx;
		sprite_bytes_t           b;
	} sprite_ent_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic shift;
		logic sort_en;
	} cell_ctl_t;

	// one result transaction
	typedef struct packed {
		logic [7:0]              read_data;
		logic                    found;
		logic [SPRITE_IDX_W-1:0] sprite_index;
		logic [7:0]              pos_x;
		logic [7:0]              pos_y;
		logic [7:0]              tile_number;
		logic [7:0]              attr_bits;
		logic [3:0]              palette_index;
		logic                    last;
	} result_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_READ  = 2'd1,
		ST_SCAN  = 2'd2,
		ST_DRAIN = 2'd3
	} state_t;

endpackage

>>> src/slsss_store.sv
// object attribute store: four byte-lane memories, one sprite per entry
// single write port, one registered read of a whole sprite per cycle
// depends on slsss_pkg

module slsss_store #(
	parameter int SPRITE_COUNT = 40,
	parameter int IDX_W        = 6
) (
	input  logic                   clk,
	input  logic                   we,
	input  logic [1:0]             wlane,
	input  logic [IDX_W-1:0]       waddr,
	input  logic [7:0]             wdata,
	input  logic [IDX_W-1:0]       raddr,
	output slsss_pkg::sprite_bytes_t rdata
);

	logic [7:0] lane_rd [4];

	// one memory per byte lane, each with its own registered read
	for (genvar k = 0; k < 4; k++) begin : g_lane
		logic [7:0] mem [SPRITE_COUNT];
		logic [7:0] rd_q;

		always_ff @(posedge clk) begin
			if (we && wlane == 2'(k)) begin
				mem[waddr] <= wdata;
			end
			rd_q <= mem[raddr];
		end

		assign lane_rd[k] = rd_q;
	end

	// lanes to sprite fields
	assign rdata.y    = lane_rd[slsss_pkg::LANE_Y];
	assign rdata.x    = lane_rd[slsss_pkg::LANE_X];
	assign rdata.tile = lane_rd[slsss_pkg::LANE_TILE];
	assign rdata.attr = lane_rd[slsss_pkg::LANE_ATTR];

endmodule

>>> src/slsss_cell.sv
// one cell of the insertion sort chain: holds one picked sprite
// takes the new pick, its upper neighbour's entry or its lower neighbour's entry
// depends on slsss_pkg

module slsss_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slsss_pkg::cell_ctl_t   ctl,
	input  slsss_pkg::sprite_ent_t new_ent,
	input  logic                   prev_valid,
	input  slsss_pkg::sprite_ent_t prev_ent,
	input  logic                   prev_disp,
	input  logic                   next_valid,
	input  slsss_pkg::sprite_ent_t next_ent,
	output logic                   valid,
	output slsss_pkg::sprite_ent_t ent,
	output logic                   disp
);

	logic                   valid_q;
	slsss_pkg::sprite_ent_t ent_q;

	// new pick lands here or above: empty cell, or strictly smaller x when sorting
	assign disp = ctl.insert &&
		(!valid_q || (ctl.sort_en && (new_ent.b.x < ent_q.b.x)));

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.shift) begin
			valid_q <= next_valid;
		end else if (prev_disp) begin
			valid_q <= prev_valid;
		end else if (disp) begin
			valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ent_q <= next_ent;
		end else if (prev_disp) begin
			ent_q <= prev_ent;
		end else if (disp) begin
			ent_q <= new_ent;
		end
	end

	assign valid = valid_q;
	assign ent   = ent_q;

endmodule

>>> src/sprite_line_scan_select_sort.sv
// top level of the sprite line scan, select and sort block
// controller, scan pipeline, sort chain and output register
// depends on slsss_pkg, slsss_store, slsss_cell

// A write, or an unused command, has its result registered at the edge that
// accepts it; a read first goes through the registered store read and is
// loaded into the output register from ST_READ once that register is free. A
// scan reads one sprite per cycle through the store's single read port, then
// drains the chain at one result per cycle while out_stall is low. Picks enter
// the chain of MAX_PER_LINE cells as they are found; with color mode off each
// cell compares x with the new pick, so the picks are already in x order when
// the scan ends, and in color mode they stay in scan order. The next
// transaction is accepted once the last result of the current one sits in the
// output register and that register is empty or handing its result over in the
// same cycle; a stalled result holds off the input.

module sprite_line_scan_select_sort #(
	parameter int SPRITE_COUNT = 40,
	parameter int MAX_PER_LINE = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	// configuration
	input  logic       cfg_write,
	input  logic       cfg_index,
	input  logic       cfg_data,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] cmd,
	input  logic [7:0] byte_offset,
	input  logic [7:0] write_value,
	input  logic [7:0] line_number,
	// output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_data,
	output logic       found,
	output logic [5:0] sprite_index,
	output logic [7:0] pos_x,
	output logic [7:0] pos_y,
	output logic [7:0] tile_number,
	output logic [7:0] attr_bits,
	output logic [3:0] palette_index,
	output logic       last
);

	localparam int IDX_W   = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
	localparam int CNT_W   = $clog2(SPRITE_COUNT + 1);
	localparam int PCK_W   = $clog2(MAX_PER_LINE + 1);
	localparam int STORE_N = SPRITE_COUNT * 4;

	// configuration registers
	logic color_q;
	logic tall_q;

	// controller
	slsss_pkg::state_t state_q;
	slsss_pkg::state_t state_d;
	logic              accept;
	logic              out_free;
	logic              in_range;
	logic [CNT_W-1:0]  scan_q;
	logic              issue;
	logic              scan_done;
	logic [7:0]        line_q;
	logic [1:0]        rd_lane_q;
	logic              rd_oob_q;
	logic [PCK_W-1:0]  count_q;

	// store access
	logic                     st_we;
	logic [IDX_W-1:0]         st_raddr;
	slsss_pkg::sprite_bytes_t st_rdata;

	// scan pipeline
	logic                  valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [9:0]            diff_s1;
	logic [8:0]            height;
	logic                  hit_s1;
	logic                  hit_s2;
	slsss_pkg::sprite_ent_t ent_s2;

	// sort chain
	slsss_pkg::cell_ctl_t   cell_ctl;
	logic [MAX_PER_LINE-1:0] cell_valid;
	logic [MAX_PER_LINE-1:0] cell_disp;
	slsss_pkg::sprite_ent_t  cell_ent [MAX_PER_LINE];
	logic                    head_last;

	// output register
	logic               out_load;
	slsss_pkg::result_t res_d;
	slsss_pkg::result_t res_q;
	logic               out_valid_q;
	logic [7:0]         attr_m;
	logic [7:0]         rd_byte;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= 1'b0;
			tall_q  <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				slsss_pkg::CFG_COLOR_MODE:   color_q <= cfg_data;
				slsss_pkg::CFG_TALL_SPRITES: tall_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// handshake and scan bookkeeping
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != slsss_pkg::ST_IDLE) || !out_free;
	assign accept    = in_valid && !in_stall;
	assign in_range  = {1'b0, byte_offset} < 9'(STORE_N);
	assign issue     = (state_q == slsss_pkg::ST_SCAN) && (scan_q < CNT_W'(SPRITE_COUNT));
	assign scan_done = (state_q == slsss_pkg::ST_SCAN) && !issue && !valid_s1 && !hit_s2;
	assign head_last = (MAX_PER_LINE == 1) ? 1'b1 : !cell_valid[(MAX_PER_LINE > 1) ? 1 : 0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			slsss_pkg::ST_IDLE: begin
				if (accept && cmd == slsss_pkg::CMD_READ) begin
					state_d = slsss_pkg::ST_READ;
				end else if (accept && cmd == slsss_pkg::CMD_SCAN) begin
					state_d = slsss_pkg::ST_SCAN;
				end
			end
			slsss_pkg::ST_READ: begin
				if (out_free) begin
					state_d = slsss_pkg::ST_IDLE;
				end
			end
			slsss_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = slsss_pkg::ST_DRAIN;
				end
			end
			slsss_pkg::ST_DRAIN: begin
				if (out_free && (!cell_valid[0] || head_last)) begin
					state_d = slsss_pkg::ST_IDLE;
				end
			end
			default: state_d = slsss_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= slsss_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// byte selected by a read
	always_comb begin
		case (rd_lane_q)
			slsss_pkg::LANE_Y:    rd_byte = st_rdata.y;
			slsss_pkg::LANE_X:    rd_byte = st_rdata.x;
			slsss_pkg::LANE_TILE: rd_byte = st_rdata.tile;
			default:              rd_byte = st_rdata.attr;
		endcase
	end

	// mode mask on the head entry's attributes
	assign attr_m = color_q ? cell_ent[0].b.attr
		: (cell_ent[0].b.attr & slsss_pkg::ATTR_MASK_MONO);

	// controller outputs: store addressing, chain control, result assembly
	always_comb begin
		st_we            = 1'b0;
		st_raddr         = scan_q[IDX_W-1:0];
		cell_ctl.insert  = hit_s2 && (count_q < PCK_W'(MAX_PER_LINE));
		cell_ctl.shift   = 1'b0;
		cell_ctl.sort_en = !color_q;
		out_load         = 1'b0;
		res_d            = '0;
		res_d.last       = 1'b1;
		case (state_q)
			slsss_pkg::ST_IDLE: begin
				st_raddr = IDX_W'(byte_offset[7:2]);
				st_we    = accept && (cmd == slsss_pkg::CMD_WRITE) && in_range;
				out_load = accept && (cmd != slsss_pkg::CMD_READ)
					&& (cmd != slsss_pkg::CMD_SCAN);
			end
			slsss_pkg::ST_READ: begin
				out_load        = out_free;
				res_d.read_data = rd_oob_q ? 8'd0 : rd_byte;
			end
			slsss_pkg::ST_SCAN: begin
				out_load = 1'b0;
			end
			slsss_pkg::ST_DRAIN: begin
				out_load       = out_free;
				cell_ctl.shift = out_free && cell_valid[0];
				if (cell_valid[0]) begin
					res_d.found         = 1'b1;
					res_d.sprite_index  = cell_ent[0].idx;
					res_d.pos_x         = cell_ent[0].b.x;
					res_d.pos_y         = cell_ent[0].b.y;
					res_d.tile_number   = cell_ent[0].b.tile;
					res_d.attr_bits     = attr_m;
					res_d.palette_index = color_q ? {1'b1, attr_m[2:0]} : {3'b000, attr_m[4]};
					res_d.last          = head_last;
				end
			end
			default: ;
		endcase
	end

	// per-transaction registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			count_q <= '0;
		end else begin
			if (accept) begin
				scan_q  <= '0;
				count_q <= '0;
			end else begin
				if (issue) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				if (cell_ctl.insert) begin
					count_q <= count_q + PCK_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q    <= line_number;
			rd_lane_q <= byte_offset[1:0];
			rd_oob_q  <= !in_range;
		end
	end

	slsss_store #(
		.SPRITE_COUNT(SPRITE_COUNT),
		.IDX_W       (IDX_W)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.wlane(byte_offset[1:0]),
		.waddr(IDX_W'(byte_offset[7:2])),
		.wdata(write_value),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	// stage 1: store data back, line coverage test
	assign height  = tall_q ? slsss_pkg::HEIGHT_TALL : slsss_pkg::HEIGHT_SHORT;
	assign diff_s1 = {2'b00, line_q} + slsss_pkg::Y_OFFSET - {2'b00, st_rdata.y};
	assign hit_s1  = valid_s1 && !diff_s1[9] && (diff_s1[8:0] < height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s2   <= 1'b0;
		end else begin
			valid_s1 <= issue;
			hit_s2   <= hit_s1;
		end
	end

	// stage 2: pick waiting for insertion
	always_ff @(posedge clk) begin
		idx_s1     <= scan_q[IDX_W-1:0];
		ent_s2.idx <= slsss_pkg::SPRITE_IDX_W'(idx_s1);
		ent_s2.b   <= st_rdata;
	end

	// chain of sort cells, cell 0 holds the next result
	for (genvar i = 0; i < MAX_PER_LINE; i++) begin : g_cell
		logic                   p_valid;
		slsss_pkg::sprite_ent_t p_ent;
		logic                   p_disp;
		logic                   n_valid;
		slsss_pkg::sprite_ent_t n_ent;

		if (i == 0) begin : g_top
			assign p_valid = 1'b0;
			assign p_ent   = '0;
			assign p_disp  = 1'b0;
		end else begin : g_mid
			assign p_valid = cell_valid[i-1];
			assign p_ent   = cell_ent[i-1];
			assign p_disp  = cell_disp[i-1];
		end

		if (i == MAX_PER_LINE - 1) begin : g_end
			assign n_valid = 1'b0;
			assign n_ent   = '0;
		end else begin : g_inner
			assign n_valid = cell_valid[i+1];
			assign n_ent   = cell_ent[i+1];
		end

		slsss_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.new_ent   (ent_s2),
			.prev_valid(p_valid),
			.prev_ent  (p_ent),
			.prev_disp (p_disp),
			.next_valid(n_valid),
			.next_ent  (n_ent),
			.valid     (cell_valid[i]),
			.ent       (cell_ent[i]),
			.disp      (cell_disp[i])
		);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= res_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign read_data     = res_q.read_data;
	assign found         = res_q.found;
	assign sprite_index  = res_q.sprite_index;
	assign pos_x         = res_q.pos_x;
	assign pos_y         = res_q.pos_y;
	assign tile_number   = res_q.tile_number;
	assign attr_bits     = res_q.attr_bits;
	assign palette_index = res_q.palette_index;
	assign last          = res_q.last;

	// the pick count never passes the chain length
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= PCK_W'(MAX_PER_LINE))
		else $error("pick count beyond chain length");

	// an insertion never pushes a pick off the end of the chain
	assert property (@(posedge clk) disable iff (!arst_n)
		cell_ctl.insert |-> !cell_valid[MAX_PER_LINE-1])
		else $error("insertion into a full chain");

	// an empty cell 0 means the whole chain is empty
	assert property (@(posedge clk) disable iff (!arst_n)
		!cell_valid[0] |-> (cell_valid == '0))
		else $error("gap at the head of the chain");

	// an accepted scan starts with an empty pick count and an empty chain
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == slsss_pkg::CMD_SCAN) |=>
		(state_q == slsss_pkg::ST_SCAN && count_q == '0 && cell_valid == '0))
		else $error("scan started with stale picks");

endmodule
